// ===== design/lis_pkg.sv =====
// Shared types, codes and widths for the indexed list store.
package lis_pkg;

	// Field widths fixed by the request and result formats.
	localparam int OP_W         = 3;
	localparam int POS_W        = 7;
	localparam int WORD_W       = 32;
	localparam int STAT_W       = 2;
	localparam int LEN_W        = 7;
	localparam int S_TDATA_W    = 48;
	localparam int M_TDATA_W    = 48;
	localparam int DEF_CAPACITY = 64;

	// Word returned by every request that is not a successful read.
	localparam logic [WORD_W-1:0] NO_VALUE = '1;

	// Operation codes.
	typedef enum logic [OP_W-1:0] {
		OP_READ   = 3'd0,
		OP_FRONT  = 3'd1,
		OP_BACK   = 3'd2,
		OP_INSERT = 3'd3,
		OP_REMOVE = 3'd4
	} op_e_t;

	// Status codes.
	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Decoded control for one request, handed from the decoder to the cell row.
	typedef struct packed {
		logic    ins;
		logic    rem;
		logic    rd_ok;
		status_t status;
	} ctrl_t;

endpackage

// ===== design/lis_decode.sv =====
// Request decoder: range and full checks and the slot that an insert or remove touches.
module lis_decode #(
	parameter int CAPACITY = lis_pkg::DEF_CAPACITY,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                     go,
	input  lis_pkg::op_e_t           op,
	input  logic [lis_pkg::POS_W-1:0] position,
	input  logic [CW-1:0]            count,
	output lis_pkg::ctrl_t           ctl,
	output logic [CW-1:0]            slot
);

	localparam int CMP_W = (CW > lis_pkg::POS_W) ? CW : lis_pkg::POS_W;

	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic             full;

	assign pos_x = CMP_W'(position);
	assign cnt_x = CMP_W'(count);
	assign full  = (count == CW'(CAPACITY));

	// Checks are made against the length before this request; ins and rem only fire with go.
	always_comb begin
		ctl        = '0;
		ctl.status = lis_pkg::ST_DONE;
		slot       = '0;
		unique case (op)
			lis_pkg::OP_READ: begin
				if (pos_x < cnt_x) begin
					ctl.rd_ok = 1'b1;
				end else begin
					ctl.status = lis_pkg::ST_RANGE;
				end
			end
			lis_pkg::OP_FRONT: begin
				slot = '0;
				if (full) begin
					ctl.status = lis_pkg::ST_FULL;
				end else begin
					ctl.ins = go;
				end
			end
			lis_pkg::OP_BACK: begin
				slot = count;
				if (full) begin
					ctl.status = lis_pkg::ST_FULL;
				end else begin
					ctl.ins = go;
				end
			end
			lis_pkg::OP_INSERT: begin
				slot = pos_x[CW-1:0];
				if (pos_x > cnt_x) begin
					ctl.status = lis_pkg::ST_RANGE;
				end else if (full) begin
					ctl.status = lis_pkg::ST_FULL;
				end else begin
					ctl.ins = go;
				end
			end
			lis_pkg::OP_REMOVE: begin
				slot = pos_x[CW-1:0];
				if (pos_x < cnt_x) begin
					ctl.rem = go;
				end else begin
					ctl.status = lis_pkg::ST_RANGE;
				end
			end
			default: begin
				ctl.status = lis_pkg::ST_RANGE;
			end
		endcase
	end

endmodule

// ===== design/lis_cells.sv =====
// Row of storage cells that shift up on insert and down on remove, with the entry count.
module lis_cells #(
	parameter int CAPACITY = lis_pkg::DEF_CAPACITY,
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lis_pkg::ctrl_t              ctl,
	input  logic [CW-1:0]               slot,
	input  logic [lis_pkg::WORD_W-1:0]  value,
	input  logic [lis_pkg::POS_W-1:0]   position,
	output logic [CW-1:0]               count,
	output logic [CW-1:0]               count_nxt,
	output logic [lis_pkg::WORD_W-1:0]  rd_data
);

	localparam int IW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W = (CW > lis_pkg::POS_W) ? CW : lis_pkg::POS_W;

	logic [lis_pkg::WORD_W-1:0] cell_q [CAPACITY];
	logic [lis_pkg::WORD_W-1:0] cell_d [CAPACITY];
	logic [CW-1:0]              count_q;
	logic [CMP_W-1:0]           pos_x;

	// Each cell picks its lower neighbor, the new word, its upper neighbor or itself.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic [lis_pkg::WORD_W-1:0] below;
		logic [lis_pkg::WORD_W-1:0] above;

		if (i == 0) begin : g_bot
			assign below = cell_q[i];
		end else begin : g_mid_lo
			assign below = cell_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_top
			assign above = cell_q[i];
		end else begin : g_mid_hi
			assign above = cell_q[i+1];
		end

		always_comb begin
			cell_d[i] = cell_q[i];
			if (ctl.ins) begin
				if (IDX > slot) begin
					cell_d[i] = below;
				end else if (IDX == slot) begin
					cell_d[i] = value;
				end
			end else if (ctl.rem) begin
				if (IDX >= slot) begin
					cell_d[i] = above;
				end
			end
		end

		always_ff @(posedge clk) begin
			cell_q[i] <= cell_d[i];
		end
	end

	// Entry count moves by one on each insert or remove.
	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + 1'b1;
		end else if (ctl.rem) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	assign count = count_q;

	// Read port; only used when the position is below the count, so truncation is safe.
	assign pos_x   = CMP_W'(position);
	assign rd_data = cell_q[pos_x[IW-1:0]];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins |=> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("insert did not grow the list by one");

	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rem |=> (count_q == CW'($past(count_q) - 1'b1)))
		else $error("remove did not shrink the list by one");

endmodule

// ===== design/indexed_list_store.sv =====
// Top level of the indexed list store: request register, decoder, cell row and result register.
// A request is held in the request register and moves on into the result register once the result side can take it.
// One request per cycle while the result side is not stalled; the cell row shifts all entries together.
// Back pressure on the result side stalls the request register, which stays ready while empty.
// Reset clears the entry count and both valid flags; cell contents are undefined until written.
module indexed_list_store #(
	parameter int CAPACITY = lis_pkg::DEF_CAPACITY
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// s_tdata: op [2:0], position [9:3], value [41:10], zeros [47:42]
	input  logic [lis_pkg::S_TDATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// m_tdata: read_value [31:0], status [33:32], length [40:34], zeros [47:41]
	output logic [lis_pkg::M_TDATA_W-1:0]   m_tdata
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                       valid_s1;
	lis_pkg::op_e_t             op_s1;
	logic [lis_pkg::POS_W-1:0]  pos_s1;
	logic [lis_pkg::WORD_W-1:0] value_s1;

	logic                       out_valid_q;
	logic [lis_pkg::WORD_W-1:0] rdval_q;
	lis_pkg::status_t           status_q;
	logic [lis_pkg::LEN_W-1:0]  length_q;

	logic                       advance;
	logic                       take;
	logic                       go;
	lis_pkg::ctrl_t             ctl;
	logic [CW-1:0]              slot;
	logic [CW-1:0]              count;
	logic [CW-1:0]              count_nxt;
	logic [lis_pkg::WORD_W-1:0] rd_data;

	// Handshake: the request stage moves on whenever the result register is free or drained.
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign take     = s_tvalid && s_tready;
	assign go       = valid_s1 && advance;

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_s1    <= lis_pkg::op_e_t'(s_tdata[2:0]);
			pos_s1   <= s_tdata[9:3];
			value_s1 <= s_tdata[41:10];
		end
	end

	lis_decode #(
		.CAPACITY(CAPACITY),
		.CW      (CW)
	) u_decode (
		.go      (go),
		.op      (op_s1),
		.position(pos_s1),
		.count   (count),
		.ctl     (ctl),
		.slot    (slot)
	);

	lis_cells #(
		.CAPACITY(CAPACITY),
		.CW      (CW)
	) u_cells (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.slot     (slot),
		.value    (value_s1),
		.position (pos_s1),
		.count    (count),
		.count_nxt(count_nxt),
		.rd_data  (rd_data)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rdval_q  <= ctl.rd_ok ? rd_data : lis_pkg::NO_VALUE;
			status_q <= ctl.status;
			length_q <= lis_pkg::LEN_W'(count_nxt);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, length_q, status_q, rdval_q};

	a_fail_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q != lis_pkg::ST_DONE)) |-> (rdval_q == lis_pkg::NO_VALUE))
		else $error("failed request returned a word");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == lis_pkg::ST_FULL)) |->
			(length_q == lis_pkg::LEN_W'(CAPACITY)))
		else $error("full status reported below capacity");

	a_go_fills: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> out_valid_q)
		else $error("request left the stage without a result");

endmodule
